// ===== hdl/symmetric_matrix_norm_unit_macros.svh =====
// assertion macros shared by the norm unit rtl
// no dependencies; taken in by `include where assertions are written
`ifndef SYMMETRIC_MATRIX_NORM_UNIT_MACROS_SVH
`define SYMMETRIC_MATRIX_NORM_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SNM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SNM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/snm_pkg.sv =====
// widths, codes and types of the symmetric matrix norm unit
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package snm_pkg;

	// element and result widths
	localparam int ELEM_BITS = 16;
	localparam int MAG_BITS = ELEM_BITS;
	localparam int SQ_BITS = 2 * ELEM_BITS;
	localparam int VAL_BITS = 22;
	localparam int SUM_BITS = 2 * VAL_BITS;
	localparam int REM_BITS = VAL_BITS + 2;

	// matrix geometry
	localparam int MAX_ORDER = 64;
	localparam int ROW_BITS = $clog2(MAX_ORDER);
	localparam int ORDER_BITS = 7;

	// square-root step counts (two radicand bits per step)
	localparam int ELEM_STEPS = SQ_BITS / 2;
	localparam int SUM_STEPS = SUM_BITS / 2;
	localparam int STEP_BITS = $clog2(SUM_STEPS);

	// configuration port
	localparam int MODE_BITS = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = ORDER_BITS;

	typedef logic [MODE_BITS-1:0] mode_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [VAL_BITS-1:0] val_t;
	typedef logic [ROW_BITS-1:0] row_t;

	// norm selection
	localparam mode_t MODE_MAX = mode_t'(0);
	localparam mode_t MODE_ONE = mode_t'(1);
	localparam mode_t MODE_FROB = mode_t'(2);
	localparam mode_t MODE_ZERO = mode_t'(3);

	// register indexes
	localparam cfg_idx_t CFG_MODE = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_UPPER = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_ORDER = cfg_idx_t'(2);

endpackage

`default_nettype wire

// ===== hdl/snm_if.sv =====
// valid/ready channel interfaces: element input, norm output, register writes
// depends on snm_pkg
`default_nettype none

// element words
interface snm_elem_if;
	logic valid;
	logic ready;
	logic signed [snm_pkg::ELEM_BITS-1:0] elem_re;
	logic signed [snm_pkg::ELEM_BITS-1:0] elem_im;
	modport source (output valid, elem_re, elem_im, input ready);
	modport sink (input valid, elem_re, elem_im, output ready);
endinterface

// norm result words
interface snm_norm_if;
	logic valid;
	logic ready;
	logic [snm_pkg::VAL_BITS-1:0] norm_value;
	modport source (output valid, norm_value, input ready);
	modport sink (input valid, norm_value, output ready);
endinterface

// register write words
interface snm_cfg_if;
	logic valid;
	logic ready;
	logic [snm_pkg::CFG_IDX_BITS-1:0] index;
	logic [snm_pkg::CFG_DATA_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/symmetric_matrix_norm_unit.sv =====
// channel   | dir | payload               | note
// elem      | in  | elem_re, elem_im      | one triangle element per word
// norm      | out | norm_value            | one word after the last element
// cfg       | in  | index, data           | register writes, always ready
//
// an element passes through accept, square, 16 steps of the shared bit-pair square-root
// unit and one row-sum ram update on the diagonal or two off it
// end of matrix: max and zero go straight to the result, one/infinity scans the
// row-sum ram, frobenius takes 22 root steps over the sum of squares
// row-sum ram uses per-row valid bits, so no clearing pass after reset
// a finished norm waits in its output register while the next matrix streams in
//
// depends on snm_pkg, snm_if and symmetric_matrix_norm_unit_macros.svh
`default_nettype none
`include "symmetric_matrix_norm_unit_macros.svh"

module symmetric_matrix_norm_unit (
	input  logic       clk,
	input  logic       arst_n,
	snm_elem_if.sink   elem,
	snm_norm_if.source norm,
	snm_cfg_if.sink    cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_WR_R = 3'd3;
	localparam logic [2:0] ST_WR_C = 3'd4;
	localparam logic [2:0] ST_END  = 3'd5;
	localparam logic [2:0] ST_SCAN = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	localparam int EB = snm_pkg::ELEM_BITS;
	localparam int SQB = snm_pkg::SQ_BITS;
	localparam int VB = snm_pkg::VAL_BITS;
	localparam int SB = snm_pkg::SUM_BITS;
	localparam int RB = snm_pkg::REM_BITS;
	localparam int OB = snm_pkg::ORDER_BITS;
	localparam int WB = snm_pkg::ROW_BITS;
	localparam int TB = snm_pkg::STEP_BITS;

	logic [2:0]            state_q;
	snm_pkg::mode_t        mode_q;
	logic                  use_upper_q;
	logic [OB-1:0]         order_q;
	snm_pkg::row_t         row_q;
	snm_pkg::row_t         col_q;

	logic [EB-1:0]         im_q;
	logic [SQB-1:0]        sq_q;
	logic [SB-1:0]         rad_q;
	logic [RB-1:0]         rem_q;
	logic [VB-1:0]         root_q;
	logic [TB-1:0]         step_q;
	logic                  fin_root_q;

	snm_pkg::val_t         max_q;
	logic [SB-1:0]         sqsum_q;
	snm_pkg::val_t         best_q;
	logic [OB-1:0]         scan_q;
	logic                  cmp_s1;
	logic [snm_pkg::MAX_ORDER-1:0] row_vld_q;

	snm_pkg::val_t         row_mem [snm_pkg::MAX_ORDER];
	snm_pkg::val_t         rd_q;
	logic                  rdv_q;

	logic                  out_vld_q;
	snm_pkg::val_t         out_val_q;

	// combinational signals
	logic [EB-1:0]         re_bits, im_bits, re_abs, im_abs;
	logic [SQB-1:0]        re_sq, im_sq, sq_total;
	logic [OB-1:0]         n_eff;
	snm_pkg::row_t         last_idx;
	logic                  is_last;
	logic [OB-1:0]         row_inc, col_inc, nr_w, nc_w;
	snm_pkg::row_t         next_row, next_col;
	logic [RB-1:0]         rem_sh, trial;
	logic                  take_bit;
	snm_pkg::val_t         rd_val, mag_ext, sum_upd, result;
	logic [SB-1:0]         sq_add;
	snm_pkg::row_t         rd_addr, mem_wa;
	logic                  mem_we;
	logic                  item_end;
	logic                  out_free;
	logic                  cfg_wr, cfg_known;

	assign elem.ready = (state_q == ST_IDLE);
	assign norm.valid = out_vld_q;
	assign norm.norm_value = out_val_q;
	assign cfg.ready = 1'b1;

	// element magnitudes
	assign re_bits = elem.elem_re;
	assign im_bits = elem.elem_im;
	assign re_abs = re_bits[EB-1] ? (~re_bits + EB'(1)) : re_bits;
	assign im_abs = im_bits[EB-1] ? (~im_bits + EB'(1)) : im_bits;
	assign re_sq = re_abs * re_abs;
	assign im_sq = im_q * im_q;
	assign sq_total = sq_q + im_sq;

	// effective order and triangle walk
	always_comb begin
		if (order_q == '0)
			n_eff = OB'(1);
		else if (order_q > OB'(snm_pkg::MAX_ORDER))
			n_eff = OB'(snm_pkg::MAX_ORDER);
		else
			n_eff = order_q;
	end
	assign last_idx = WB'(n_eff - OB'(1));
	assign is_last = (row_q == last_idx) && (col_q == last_idx);
	assign row_inc = OB'(row_q) + OB'(1);
	assign col_inc = OB'(col_q) + OB'(1);

	always_comb begin
		if (use_upper_q) begin
			if (row_inc > OB'(col_q)) begin
				nr_w = '0;
				nc_w = col_inc;
			end else begin
				nr_w = row_inc;
				nc_w = OB'(col_q);
			end
		end else begin
			if (row_inc >= n_eff) begin
				nr_w = col_inc;
				nc_w = col_inc;
			end else begin
				nr_w = row_inc;
				nc_w = OB'(col_q);
			end
		end
		if (nc_w >= n_eff || nr_w >= n_eff) begin
			next_row = '0;
			next_col = '0;
		end else begin
			next_row = nr_w[WB-1:0];
			next_col = nc_w[WB-1:0];
		end
	end

	// one bit-pair step of the square root
	assign rem_sh = {rem_q[RB-3:0], rad_q[SB-1:SB-2]};
	assign trial = {root_q, 2'b01};
	assign take_bit = (rem_sh >= trial);

	// row-sum update and read port
	assign rd_val = rdv_q ? rd_q : '0;
	assign mag_ext = VB'(root_q[snm_pkg::MAG_BITS-1:0]);
	assign sum_upd = rd_val + mag_ext;
	assign sq_add = (row_q == col_q) ? SB'(sq_q) : SB'({sq_q, 1'b0});
	assign mem_we = (state_q == ST_WR_R) || (state_q == ST_WR_C);
	assign mem_wa = (state_q == ST_WR_C) ? col_q : row_q;

	always_comb begin
		if (state_q == ST_SCAN)
			rd_addr = scan_q[WB-1:0];
		else if (state_q == ST_WR_R)
			rd_addr = col_q;
		else
			rd_addr = row_q;
	end

	assign item_end = ((state_q == ST_WR_R) && (row_q == col_q)) || (state_q == ST_WR_C);
	assign out_free = !out_vld_q || norm.ready;
	assign cfg_wr = cfg.valid && cfg.ready;
	assign cfg_known = (cfg.index == snm_pkg::CFG_MODE) || (cfg.index == snm_pkg::CFG_UPPER) ||
		(cfg.index == snm_pkg::CFG_ORDER);

	// norm selection
	always_comb begin
		case (mode_q)
			snm_pkg::MODE_MAX:  result = max_q;
			snm_pkg::MODE_ONE:  result = best_q;
			snm_pkg::MODE_FROB: result = root_q;
			default:            result = '0;
		endcase
	end

	// row-sum ram, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			row_mem[mem_wa] <= sum_upd;
		rd_q <= row_mem[rd_addr];
		rdv_q <= row_vld_q[rd_addr];
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= snm_pkg::MODE_MAX;
			use_upper_q <= 1'b1;
			order_q <= OB'(1);
			row_q <= '0;
			col_q <= '0;
			im_q <= '0;
			sq_q <= '0;
			rad_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			step_q <= '0;
			fin_root_q <= 1'b0;
			max_q <= '0;
			sqsum_q <= '0;
			best_q <= '0;
			scan_q <= '0;
			cmp_s1 <= 1'b0;
			row_vld_q <= '0;
			out_vld_q <= 1'b0;
			out_val_q <= '0;
		end else begin
			if (out_vld_q && norm.ready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (elem.valid) begin
						sq_q <= re_sq;
						im_q <= im_abs;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					sq_q <= sq_total;
					rad_q <= {sq_total, (SB - SQB)'(0)};
					rem_q <= '0;
					root_q <= '0;
					step_q <= TB'(snm_pkg::ELEM_STEPS - 1);
					fin_root_q <= 1'b0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					rad_q <= {rad_q[SB-3:0], 2'b00};
					if (take_bit) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[VB-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[VB-2:0], 1'b0};
					end
					if (step_q == '0)
						state_q <= fin_root_q ? ST_FIN : ST_WR_R;
					else
						step_q <= step_q - TB'(1);
				end
				ST_WR_R: begin
					if (mag_ext > max_q)
						max_q <= mag_ext;
					sqsum_q <= sqsum_q + sq_add;
					row_vld_q[row_q] <= 1'b1;
					if (row_q != col_q)
						state_q <= ST_WR_C;
				end
				ST_WR_C: begin
					row_vld_q[col_q] <= 1'b1;
				end
				ST_END: begin
					case (mode_q)
						snm_pkg::MODE_ONE: begin
							scan_q <= '0;
							cmp_s1 <= 1'b0;
							best_q <= '0;
							state_q <= ST_SCAN;
						end
						snm_pkg::MODE_FROB: begin
							rad_q <= sqsum_q;
							rem_q <= '0;
							root_q <= '0;
							step_q <= TB'(snm_pkg::SUM_STEPS - 1);
							fin_root_q <= 1'b1;
							state_q <= ST_ROOT;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_SCAN: begin
					if (cmp_s1 && rd_val > best_q)
						best_q <= rd_val;
					if (scan_q == n_eff) begin
						state_q <= ST_FIN;
					end else begin
						scan_q <= scan_q + OB'(1);
						cmp_s1 <= 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_val_q <= result;
						out_vld_q <= 1'b1;
						max_q <= '0;
						sqsum_q <= '0;
						row_vld_q <= '0;
						row_q <= '0;
						col_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// end of an element: step through the triangle or close the matrix
			if (item_end) begin
				if (is_last) begin
					state_q <= ST_END;
				end else begin
					row_q <= next_row;
					col_q <= next_col;
					state_q <= ST_IDLE;
				end
			end

			// writes to a known register start a new matrix
			if (cfg_wr) begin
				unique case (cfg.index)
					snm_pkg::CFG_MODE:  mode_q <= cfg.data[snm_pkg::MODE_BITS-1:0];
					snm_pkg::CFG_UPPER: use_upper_q <= cfg.data[0];
					snm_pkg::CFG_ORDER: order_q <= cfg.data[OB-1:0];
					default: ;
				endcase
				if (cfg_known) begin
					max_q <= '0;
					sqsum_q <= '0;
					row_vld_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end
			end
		end
	end

	// checks
	`SNM_ASSERT_IMP(a_elem_root_width, clk, arst_n, state_q == ST_WR_R, root_q[VB-1:snm_pkg::MAG_BITS] == '0, "element magnitude wider than expected")
	`SNM_ASSERT_IMP(a_pos_in_triangle, clk, arst_n, state_q == ST_IDLE, (row_q <= last_idx) && (col_q <= last_idx) && (use_upper_q ? (row_q <= col_q) : (row_q >= col_q)), "position outside stored triangle")
	`SNM_ASSERT_NXT(a_clear_after_result, clk, arst_n, (state_q == ST_FIN) && out_free, (row_vld_q == '0) && (sqsum_q == '0) && (state_q == ST_IDLE), "matrix state not cleared after result")
	`SNM_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_SCAN, scan_q <= n_eff, "row-sum scan ran past matrix order")

endmodule

`default_nettype wire

// ===== sim/tb_symmetric_matrix_norm_unit.sv =====
// testbench for symmetric_matrix_norm_unit: streams matrix triangles, predicts each norm
// depends on snm_pkg, snm_if and the rtl top level; self-checking, no files read
`timescale 1ns / 100ps

module tb_symmetric_matrix_norm_unit;
	import snm_pkg::*;

	typedef logic signed [ELEM_BITS-1:0] elem_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

	// index with no register behind it
	localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(3);

	localparam int RAND_ITEMS = 300;
	localparam int MIN_PHASES = 6;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 2000;
	localparam longint unsigned VAL_LIMIT = (64'd1 << VAL_BITS) - 1;
	localparam longint unsigned SQ_LIMIT = (64'd1 << SUM_BITS) - 1;

	// norm predictor and store of expected norm words
	class norm_scoreboard;
		mode_t mode;
		bit upper;
		logic [ORDER_BITS-1:0] ord;
		longint unsigned row_sum[MAX_ORDER];
		longint unsigned peak;
		longint unsigned sq_total;
		int unsigned row;
		int unsigned col;
		val_t expected_norms[$];
		int errors;

		function new();
			mode = MODE_MAX;
			upper = 1'b1;
			ord = 1;
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (row_sum[k]) row_sum[k] = 0;
			peak = 0;
			sq_total = 0;
			row = 0;
			col = 0;
		endfunction

		function int unsigned eff_order();
			if (ord == 0) return 1;
			if (ord > MAX_ORDER) return MAX_ORDER;
			return ord;
		endfunction

		function int pending();
			return expected_norms.size();
		endfunction

		function longint unsigned floor_root(input longint unsigned x);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'h4000_0000_0000_0000;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint unsigned sat_add(input longint unsigned a, b, lim);
			if (a + b > lim) return lim;
			return a + b;
		endfunction

		// register write: any known register clears the running matrix
		function void note_cfg(input cfg_idx_t idx, input cfg_data_t value);
			case (idx)
				CFG_MODE: mode = value[MODE_BITS-1:0];
				CFG_UPPER: upper = value[0];
				CFG_ORDER: ord = value[ORDER_BITS-1:0];
				default: return;
			endcase
			clear();
		endfunction

		// accepted element word: accumulate, and at the end of the triangle queue the norm
		function void note_elem(input elem_t re, input elem_t im);
			longint ar;
			longint ai;
			longint unsigned sq;
			longint unsigned mag;
			longint unsigned res;
			int unsigned n;
			int unsigned r;
			int unsigned c;
			bit last;
			n = eff_order();
			r = row % MAX_ORDER;
			c = col % MAX_ORDER;
			ar = re;
			ai = im;
			if (ar < 0) ar = -ar;
			if (ai < 0) ai = -ai;
			sq = ar * ar + ai * ai;
			mag = floor_root(sq);
			if (mag > VAL_LIMIT) mag = VAL_LIMIT;
			if (mag > peak) peak = mag;
			row_sum[r] = sat_add(row_sum[r], mag, VAL_LIMIT);
			sq_total = sat_add(sq_total, sq, SQ_LIMIT);
			// off-diagonal elements stand for their mirror too
			if (r != c) begin
				row_sum[c] = sat_add(row_sum[c], mag, VAL_LIMIT);
				sq_total = sat_add(sq_total, sq, SQ_LIMIT);
			end
			last = (r == n - 1) && (c == n - 1);
			if (!last) begin
				if (upper) begin
					r++;
					if (r > c) begin
						c++;
						r = 0;
					end
				end else begin
					r++;
					if (r >= n) begin
						c++;
						r = c;
					end
				end
				if (c >= n || r >= n) begin
					r = 0;
					c = 0;
				end
				row = r;
				col = c;
				return;
			end
			res = 0;
			case (mode)
				MODE_MAX: res = peak;
				MODE_ONE: begin
					for (int k = 0; k < n; k++)
						if (row_sum[k] > res) res = row_sum[k];
				end
				MODE_FROB: begin
					res = floor_root(sq_total);
					if (res > VAL_LIMIT) res = VAL_LIMIT;
				end
				default: res = 0;
			endcase
			expected_norms.push_back(val_t'(res));
			clear();
		endfunction

		// accepted norm word against the oldest expectation
		function void check_norm(input val_t act);
			val_t exp_val;
			if (expected_norms.size() == 0) begin
				$display("%0t: norm word with nothing expected, expected none, got %0d",
					$time, act);
				errors++;
				return;
			end
			exp_val = expected_norms.pop_front();
			if (act !== exp_val) begin
				$display("%0t: norm_value mismatch, expected %0d, got %0d",
					$time, exp_val, act);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	snm_elem_if elem_ch();
	snm_norm_if norm_ch();
	snm_cfg_if cfg_ch();

	symmetric_matrix_norm_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem_ch),
		.norm(norm_ch),
		.cfg(cfg_ch)
	);

	norm_scoreboard board;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_reqs;
	int unsigned rand_items;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls, long hold-offs on request, checking
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned holds_seen;
		hold_left = 0;
		holds_seen = 0;
		norm_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (norm_ch.valid && norm_ch.ready) board.check_norm(norm_ch.norm_value);
			if (hold_reqs != holds_seen) begin
				holds_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				norm_ch.ready <= 1'b0;
			end else begin
				norm_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// random element value, weighted towards the extremes
	function automatic elem_t rand_field();
		case ($urandom_range(7))
			0: return elem_t'(16'h8000);
			1: return elem_t'(16'h7FFF);
			2: return elem_t'(0);
			3: return elem_t'($urandom_range(32) - 16);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// one element word, with random sender gaps before it
	task automatic send_elem(input elem_t re, input elem_t im);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			elem_ch.valid <= 1'b0;
			@(posedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.elem_re <= re;
		elem_ch.elem_im <= im;
		@(posedge clk);
		while (!elem_ch.ready) @(posedge clk);
		board.note_elem(re, im);
	endtask

	// part or all of a triangle; peak sends the most negative value throughout
	task automatic send_triangle(input bit peak_vals, input int limit);
		int unsigned n;
		int count;
		n = board.eff_order();
		count = n * (n + 1) / 2;
		if (limit >= 0 && limit < count) count = limit;
		for (int k = 0; k < count; k++) begin
			if (peak_vals) send_elem(elem_t'(16'h8000), elem_t'(16'h8000));
			else send_elem(rand_field(), rand_field());
		end
	endtask

	// block idle: nothing expected and the pipeline drained
	task automatic settle();
		elem_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		board.note_cfg(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cfg_data_t rand_order();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5) return cfg_data_t'(0);
		if (pick < 80) return cfg_data_t'($urandom_range(5, 1));
		return cfg_data_t'($urandom_range(12, 6));
	endfunction

	// main sequence
	initial begin : stimulus
		int unsigned mask;
		int unsigned mats;
		int phase;
		cfg_data_t value;
		board = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_reqs = 0;
		rand_items = 0;
		elem_ch.valid <= 1'b0;
		elem_ch.elem_re <= '0;
		elem_ch.elem_im <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_MODE;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: largest magnitude, order one
		send_elem(elem_t'(16'h7FFF), elem_t'(16'h7FFF));
		send_elem(elem_t'(16'h8000), elem_t'(16'h8000));
		send_elem(elem_t'(0), elem_t'(0));
		send_elem(elem_t'(-1), elem_t'(1));

		// one/infinity on an upper order-two triangle
		settle();
		write_reg(CFG_MODE, cfg_data_t'(MODE_ONE));
		write_reg(CFG_ORDER, cfg_data_t'(2));
		send_elem(elem_t'(16'h8000), elem_t'(0));
		send_elem(elem_t'(0), elem_t'(16'h8000));
		send_elem(elem_t'(16'h7FFF), elem_t'(16'h8000));

		// frobenius on a lower triangle
		settle();
		write_reg(CFG_UPPER, cfg_data_t'(0));
		write_reg(CFG_MODE, cfg_data_t'(MODE_FROB));
		send_triangle(1'b0, -1);

		// zero mode still gives a word
		settle();
		write_reg(CFG_MODE, cfg_data_t'(MODE_ZERO));
		send_triangle(1'b1, -1);

		// order zero acts as one
		settle();
		write_reg(CFG_ORDER, cfg_data_t'(0));
		write_reg(CFG_MODE, cfg_data_t'(MODE_MAX));
		send_triangle(1'b0, 2);

		// a register write drops a half-streamed matrix
		settle();
		write_reg(CFG_UPPER, cfg_data_t'(1));
		write_reg(CFG_ORDER, cfg_data_t'(3));
		send_triangle(1'b0, 2);
		settle();
		write_reg(CFG_MODE, cfg_data_t'(MODE_ONE));
		send_triangle(1'b0, -1);

		// a write to the spare index leaves the matrix running
		settle();
		write_reg(CFG_ORDER, cfg_data_t'(2));
		send_triangle(1'b0, 1);
		settle();
		write_reg(CFG_SPARE, cfg_data_t'(7'h7F));
		send_triangle(1'b0, 2);

		// largest order, full-scale elements: top of the row-sum range
		settle();
		write_reg(CFG_ORDER, cfg_data_t'(7'h7F));
		send_triangle(1'b1, -1);

		// frobenius over a full-scale lower triangle
		settle();
		write_reg(CFG_ORDER, cfg_data_t'(8));
		write_reg(CFG_UPPER, cfg_data_t'(0));
		write_reg(CFG_MODE, cfg_data_t'(MODE_FROB));
		send_triangle(1'b1, -1);

		// random phases over the idling profiles
		phase = 0;
		while (rand_items < RAND_ITEMS || phase < MIN_PHASES) begin
			settle();
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			mask = $urandom_range(7, 1);
			if (mask[0]) begin
				value = cfg_data_t'($urandom);
				value[MODE_BITS-1:0] = mode_t'($urandom_range(3));
				write_reg(CFG_MODE, value);
			end
			if (mask[1]) write_reg(CFG_UPPER, cfg_data_t'($urandom));
			if (mask[2]) write_reg(CFG_ORDER, rand_order());
			mats = $urandom_range(6, 2);
			// output held off while tiny matrices keep coming, so the block backs up
			if (phase == 3) begin
				write_reg(CFG_ORDER, cfg_data_t'($urandom_range(2, 1)));
				hold_reqs++;
				mats = 20;
			end
			for (int m = 0; m < mats; m++) begin
				send_triangle(1'b0, -1);
				rand_items += board.eff_order() * (board.eff_order() + 1) / 2;
				// sender waits for every outstanding norm mid-phase
				if (phase == 5 && m == 0) begin
					elem_ch.valid <= 1'b0;
					while (board.pending() != 0) @(posedge clk);
				end
			end
			// broken sequence: a triangle cut short, dropped by the next write
			if ($urandom_range(9) == 0 && board.eff_order() > 1) begin
				send_triangle(1'b0, $urandom_range(board.eff_order() - 1, 1));
			end
			phase++;
		end

		// drain
		elem_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t: %0d norm words never arrived", $time, board.pending());
			board.errors++;
		end
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
